// ----- rtl/assert_macros.svh -----
// Assertion macros for the receiver RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define FWIC_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("fwic assertion failed");

// Condition must never be seen outside reset.
`define FWIC_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("fwic forbidden condition seen");

`endif

// ----- rtl/fwic_pkg.sv -----
// Types, constants and the CRC table of the firmware image receiver.
package fwic_pkg;

   localparam int BUFFER_BYTES = 65536;
   localparam int COUNT_W      = $clog2(BUFFER_BYTES + 1);
   localparam int HEADER_BYTES = 12;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
   localparam logic [31:0] CRC_INIT  = 32'hFFFFFFFF;
   localparam logic [7:0]  SYNC_BYTE = 8'h55;

   localparam int          IDLE_W    = 21;
   localparam logic [IDLE_W-1:0] IDLE_MAX = '1;
   localparam logic [2:0]  RETRY_SAT = 3'd7;

   localparam int CSR_ADDR_W = 5;
   localparam logic [2:0] REG_TIMEOUT     = 3'd0;
   localparam logic [2:0] REG_RETRY_LIMIT = 3'd1;
   localparam logic [2:0] REG_STACK_LOW   = 3'd2;
   localparam logic [2:0] REG_STACK_HIGH  = 3'd3;
   localparam logic [2:0] REG_ENTRY_LOW   = 3'd4;
   localparam logic [2:0] REG_ENTRY_HIGH  = 3'd5;

   localparam logic [19:0] TIMEOUT_RST     = 20'd20000;
   localparam logic [2:0]  RETRY_LIMIT_RST = 3'd3;
   localparam logic [31:0] STACK_LOW_RST   = 32'h20000000;
   localparam logic [31:0] STACK_HIGH_RST  = 32'h20020000;
   localparam logic [31:0] ENTRY_LOW_RST   = 32'h08008000;
   localparam logic [31:0] ENTRY_HIGH_RST  = 32'h08080000;

   typedef enum logic {ITEM_BYTE, ITEM_TICK} item_kind_type;

   typedef struct packed {
      item_kind_type kind;
      logic          is_sync;
      logic [7:0]    data;
   } q_item_type;

   typedef struct packed {
      logic [19:0] timeout_ticks;
      logic [2:0]  retry_limit;
      logic [31:0] stack_low;
      logic [31:0] stack_high;
      logic [31:0] entry_low;
      logic [31:0] entry_high;
   } cfg_type;

   typedef enum logic [1:0] {RSP_ACK, RSP_NAK, RSP_FATAL, RSP_RESET} rsp_code_type;
   typedef enum logic [1:0] {CAUSE_NONE, CAUSE_CRC, CAUSE_VECTOR, CAUSE_TIMEOUT} cause_type;

   typedef logic [31:0] crc_table_type [256];

   function automatic crc_table_type crc_table_build();
      crc_table_type t;
      logic [31:0]   c;
      for (int i = 0; i < 256; i++) begin
         c = 32'(i);
         for (int k = 0; k < 8; k++) begin
            c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
         end
         t[i] = c;
      end
      return t;
   endfunction

   localparam crc_table_type CRC_TABLE = crc_table_build();

endpackage

// ----- rtl/fwic_channels.sv -----
// Request and response channel interfaces of the firmware image receiver.
interface fwic_req_if;
   logic       valid;
   logic       ready;
   logic       command;
   logic [7:0] data_byte;

   modport source (output valid, output command, output data_byte, input ready);
   modport sink   (input valid, input command, input data_byte, output ready);
endinterface

interface fwic_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  response;
   logic [1:0]  cause;
   logic [2:0]  attempt;
   logic [31:0] computed_crc;

   modport source (output valid, output response, output cause, output attempt,
                   output computed_crc, input ready);
   modport sink   (input valid, input response, input cause, input attempt,
                   input computed_crc, output ready);
endinterface

// ----- rtl/fwic_csr.sv -----
// APB-style configuration registers of the firmware image receiver.
module fwic_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [fwic_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                    csr_pwdata,
   output logic [31:0]                    csr_prdata,
   output logic                           csr_pready,
   output fwic_pkg::cfg_type              cfg
);
   import fwic_pkg::*;

   cfg_type    cfg_ff;
   logic       wr_en;
   logic [2:0] reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = csr_paddr[4:2];
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.timeout_ticks <= TIMEOUT_RST;
         cfg_ff.retry_limit   <= RETRY_LIMIT_RST;
         cfg_ff.stack_low     <= STACK_LOW_RST;
         cfg_ff.stack_high    <= STACK_HIGH_RST;
         cfg_ff.entry_low     <= ENTRY_LOW_RST;
         cfg_ff.entry_high    <= ENTRY_HIGH_RST;
      end else if (wr_en) begin
         unique case (reg_idx)
            REG_TIMEOUT:     cfg_ff.timeout_ticks <= csr_pwdata[19:0];
            REG_RETRY_LIMIT: cfg_ff.retry_limit   <= csr_pwdata[2:0];
            REG_STACK_LOW:   cfg_ff.stack_low     <= csr_pwdata;
            REG_STACK_HIGH:  cfg_ff.stack_high    <= csr_pwdata;
            REG_ENTRY_LOW:   cfg_ff.entry_low     <= csr_pwdata;
            REG_ENTRY_HIGH:  cfg_ff.entry_high    <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_TIMEOUT:     csr_prdata = 32'(cfg_ff.timeout_ticks);
         REG_RETRY_LIMIT: csr_prdata = 32'(cfg_ff.retry_limit);
         REG_STACK_LOW:   csr_prdata = cfg_ff.stack_low;
         REG_STACK_HIGH:  csr_prdata = cfg_ff.stack_high;
         REG_ENTRY_LOW:   csr_prdata = cfg_ff.entry_low;
         REG_ENTRY_HIGH:  csr_prdata = cfg_ff.entry_high;
         default:         csr_prdata = '0;
      endcase
   end

endmodule

// ----- rtl/fwic_front.sv -----
// Front end: accepts requests, classifies them and queues them for the back end.
module fwic_front (
   input  logic                 clock,
   input  logic                 reset,
   fwic_req_if.sink             req_chan,
   output logic                 q_valid,
   output fwic_pkg::q_item_type q_item,
   input  logic                 q_pop
);
   import fwic_pkg::*;

   q_item_type        q_mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;
   logic [QCNT_W-1:0] count_in;
   logic              push;
   q_item_type        new_item;

   assign req_chan.ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign push           = req_chan.valid && req_chan.ready;

   always_comb begin
      new_item.kind    = req_chan.command ? ITEM_TICK : ITEM_BYTE;
      new_item.is_sync = (req_chan.data_byte == SYNC_BYTE);
      new_item.data    = req_chan.data_byte;
   end

   always_comb begin
      count_in = count_ff;
      if (push && !q_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (q_pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= new_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (q_pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

   assign q_valid = (count_ff != '0);
   assign q_item  = q_mem_ff[rd_ptr_ff];

endmodule

// ----- rtl/fwic_back.sv -----
// Back end: receive state, CRC update, image check and response register.
module fwic_back (
   input  logic                 clock,
   input  logic                 reset,
   input  fwic_pkg::cfg_type    cfg,
   input  logic                 q_valid,
   input  fwic_pkg::q_item_type q_item,
   output logic                 q_pop,
   fwic_rsp_if.source           rsp_chan
);
   import fwic_pkg::*;

   logic               synced_ff, synced_in;
   logic [COUNT_W-1:0] byte_count_ff, byte_count_in;
   logic [31:0]        expected_crc_ff, expected_crc_in;
   logic [31:0]        image_size_ff, image_size_in;
   logic [31:0]        running_crc_ff, running_crc_in;
   logic [31:0]        stack_word_ff, stack_word_in;
   logic [31:0]        entry_word_ff, entry_word_in;
   logic [2:0]         retry_ff, retry_in;
   logic [IDLE_W-1:0]  idle_ff, idle_in;

   // image completion is held here for its checks until the response slot is free
   logic               resolve_ff, resolve_in;
   logic [31:0]        fin_crc_ff, fin_crc_in;
   logic [31:0]        fin_exp_ff, fin_exp_in;
   logic [31:0]        fin_stack_ff, fin_stack_in;
   logic [31:0]        fin_entry_ff, fin_entry_in;

   logic               out_valid_ff, out_valid_in;
   rsp_code_type       out_rsp_ff, out_rsp_in;
   cause_type          out_cause_ff, out_cause_in;
   logic [2:0]         out_att_ff, out_att_in;
   logic [31:0]        out_crc_ff, out_crc_in;

   logic               slot_free;
   logic [31:0]        crc_upd;
   logic [COUNT_W-1:0] pos;
   logic [COUNT_W-1:0] count_next;
   logic [32:0]        end_count;
   logic [4:0]         lane_sh;
   logic               crc_bad;
   logic               vec_ok;
   logic [2:0]         retry_inc;
   logic [IDLE_W-1:0]  idle_inc;
   logic               timed_out;
   cause_type          fail_cause;

   assign slot_free  = !out_valid_ff || rsp_chan.ready;
   assign pos        = byte_count_ff;
   assign count_next = byte_count_ff + COUNT_W'(1);
   assign end_count  = 33'(image_size_ff) + 33'(HEADER_BYTES);
   assign lane_sh    = {pos[1:0], 3'b000};
   assign crc_upd    = (running_crc_ff >> 8) ^ CRC_TABLE[running_crc_ff[7:0] ^ q_item.data];

   assign crc_bad    = (fin_crc_ff != fin_exp_ff);
   assign vec_ok     = (fin_stack_ff >= cfg.stack_low) && (fin_stack_ff <= cfg.stack_high) &&
                       (fin_entry_ff >= cfg.entry_low) && (fin_entry_ff <= cfg.entry_high);
   assign fail_cause = crc_bad ? CAUSE_CRC : CAUSE_VECTOR;
   assign retry_inc  = (retry_ff == RETRY_SAT) ? retry_ff : retry_ff + 3'd1;
   assign idle_inc   = (idle_ff == IDLE_MAX) ? idle_ff : idle_ff + IDLE_W'(1);
   assign timed_out  = idle_inc > IDLE_W'(cfg.timeout_ticks);

   always_comb begin
      synced_in       = synced_ff;
      byte_count_in   = byte_count_ff;
      expected_crc_in = expected_crc_ff;
      image_size_in   = image_size_ff;
      running_crc_in  = running_crc_ff;
      stack_word_in   = stack_word_ff;
      entry_word_in   = entry_word_ff;
      retry_in        = retry_ff;
      idle_in         = idle_ff;
      resolve_in      = resolve_ff;
      fin_crc_in      = fin_crc_ff;
      fin_exp_in      = fin_exp_ff;
      fin_stack_in    = fin_stack_ff;
      fin_entry_in    = fin_entry_ff;
      out_valid_in    = out_valid_ff && !rsp_chan.ready;
      out_rsp_in      = out_rsp_ff;
      out_cause_in    = out_cause_ff;
      out_att_in      = out_att_ff;
      out_crc_in      = out_crc_ff;
      q_pop           = 1'b0;

      if (resolve_ff) begin
         if (slot_free) begin
            resolve_in   = 1'b0;
            out_valid_in = 1'b1;
            out_crc_in   = fin_crc_ff;
            if (!crc_bad && vec_ok) begin
               out_rsp_in   = RSP_ACK;
               out_cause_in = CAUSE_NONE;
               out_att_in   = 3'd0;
               retry_in     = 3'd0;
               synced_in    = 1'b0;
            end else begin
               out_cause_in = fail_cause;
               out_att_in   = retry_inc;
               if (retry_inc >= cfg.retry_limit) begin
                  out_rsp_in = RSP_FATAL;
                  retry_in   = 3'd0;
                  synced_in  = 1'b0;
               end else begin
                  out_rsp_in = RSP_NAK;
                  retry_in   = retry_inc;
                  synced_in  = crc_bad;
               end
            end
         end
      end else if (q_valid && slot_free) begin
         q_pop = 1'b1;
         unique case (q_item.kind)
            ITEM_TICK: begin
               if (synced_ff) begin
                  if (timed_out) begin
                     out_valid_in    = 1'b1;
                     out_rsp_in      = RSP_RESET;
                     out_cause_in    = CAUSE_TIMEOUT;
                     out_att_in      = retry_ff;
                     out_crc_in      = '0;
                     synced_in       = 1'b0;
                     retry_in        = 3'd0;
                     idle_in         = '0;
                     byte_count_in   = '0;
                     expected_crc_in = '0;
                     image_size_in   = '0;
                     running_crc_in  = CRC_INIT;
                     stack_word_in   = '0;
                     entry_word_in   = '0;
                  end else begin
                     idle_in = idle_inc;
                  end
               end
            end
            ITEM_BYTE: begin
               if (!synced_ff) begin
                  if (q_item.is_sync) begin
                     synced_in = 1'b1;
                     retry_in  = 3'd0;
                     idle_in   = '0;
                  end
               end else begin
                  idle_in = '0;
                  // drop bytes once the buffer is full
                  if (byte_count_ff < COUNT_W'(BUFFER_BYTES)) begin
                     byte_count_in = count_next;
                     priority if (pos < COUNT_W'(4)) begin
                     end else if (pos < COUNT_W'(8)) begin
                        expected_crc_in[lane_sh +: 8] = q_item.data;
                     end else if (pos < COUNT_W'(HEADER_BYTES)) begin
                        image_size_in[lane_sh +: 8] = q_item.data;
                     end else begin
                        running_crc_in = crc_upd;
                        if (pos < COUNT_W'(16)) begin
                           stack_word_in[lane_sh +: 8] = q_item.data;
                        end else if (pos < COUNT_W'(20)) begin
                           entry_word_in[lane_sh +: 8] = q_item.data;
                        end
                     end

                     if ((pos == COUNT_W'(HEADER_BYTES - 1) && image_size_in == '0) ||
                         (pos >= COUNT_W'(HEADER_BYTES) && 33'(count_next) == end_count)) begin
                        resolve_in      = 1'b1;
                        fin_crc_in      = ~running_crc_in;
                        fin_exp_in      = expected_crc_in;
                        fin_stack_in    = stack_word_in;
                        fin_entry_in    = entry_word_in;
                        byte_count_in   = '0;
                        expected_crc_in = '0;
                        image_size_in   = '0;
                        running_crc_in  = CRC_INIT;
                        stack_word_in   = '0;
                        entry_word_in   = '0;
                     end
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         synced_ff       <= 1'b0;
         byte_count_ff   <= '0;
         expected_crc_ff <= '0;
         image_size_ff   <= '0;
         running_crc_ff  <= CRC_INIT;
         stack_word_ff   <= '0;
         entry_word_ff   <= '0;
         retry_ff        <= '0;
         idle_ff         <= '0;
         resolve_ff      <= 1'b0;
         out_valid_ff    <= 1'b0;
      end else begin
         synced_ff       <= synced_in;
         byte_count_ff   <= byte_count_in;
         expected_crc_ff <= expected_crc_in;
         image_size_ff   <= image_size_in;
         running_crc_ff  <= running_crc_in;
         stack_word_ff   <= stack_word_in;
         entry_word_ff   <= entry_word_in;
         retry_ff        <= retry_in;
         idle_ff         <= idle_in;
         resolve_ff      <= resolve_in;
         out_valid_ff    <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fin_crc_ff   <= fin_crc_in;
      fin_exp_ff   <= fin_exp_in;
      fin_stack_ff <= fin_stack_in;
      fin_entry_ff <= fin_entry_in;
      out_rsp_ff   <= out_rsp_in;
      out_cause_ff <= out_cause_in;
      out_att_ff   <= out_att_in;
      out_crc_ff   <= out_crc_in;
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.response     = out_rsp_ff;
   assign rsp_chan.cause        = out_cause_ff;
   assign rsp_chan.attempt      = out_att_ff;
   assign rsp_chan.computed_crc = out_crc_ff;

endmodule

// ----- rtl/firmware_image_receiver_crc_check_core.sv -----
// Path: a tick's response passes through the queue and the response register;
// an image-completing byte's response also passes the resolve register for the checks.
// Throughput: one request per cycle through a four-entry queue while it has room; each finished
// image holds the back end while its checks resolve, and a response waiting on rsp_chan stalls the back end.
// Reset: synchronous, active high; clears the queue pointers, receive state, pending check and response valid at once.
// Top level of the firmware image receiver with CRC-32 check.
`include "assert_macros.svh"

module firmware_image_receiver_crc_check_core (
   input  logic                            clock,
   input  logic                            reset,
   fwic_req_if.sink                        req_chan,
   fwic_rsp_if.source                      rsp_chan,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [fwic_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);
   import fwic_pkg::*;

   cfg_type    cfg;
   logic       q_valid;
   q_item_type q_item;
   logic       q_pop;

   fwic_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   fwic_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_valid  (q_valid),
      .q_item   (q_item),
      .q_pop    (q_pop)
   );

   fwic_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .q_valid  (q_valid),
      .q_item   (q_item),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan)
   );

   `FWIC_NEVER(a_pop_empty, clock, reset, q_pop && !q_valid)
   `FWIC_ASSERT(a_ack_clean, clock, reset, rsp_chan.valid && rsp_chan.response == RSP_ACK |-> rsp_chan.cause == CAUSE_NONE && rsp_chan.attempt == 3'd0)
   `FWIC_ASSERT(a_reset_req_form, clock, reset, rsp_chan.valid && rsp_chan.response == RSP_RESET |-> rsp_chan.cause == CAUSE_TIMEOUT && rsp_chan.computed_crc == 32'd0)

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// Testbench of the firmware image receiver: directed and random byte streams checked by a predictor.
module tb;
   import fwic_pkg::*;

   localparam int SETTLE_CYCLES = 16;

   typedef logic [7:0] byte_queue_type [$];

   typedef struct {
      logic               synced;
      logic [COUNT_W-1:0] byte_count;
      logic [31:0]        expected_crc;
      logic [31:0]        image_size;
      logic [31:0]        running_crc;
      logic [31:0]        stack_word;
      logic [31:0]        entry_word;
      logic [2:0]         retries;
      logic [IDLE_W-1:0]  idle_ticks;
   } rx_state_type;

   typedef struct {
      rsp_code_type response;
      cause_type    cause;
      logic [2:0]   attempt;
      logic [31:0]  computed_crc;
   } reply_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   fwic_req_if req_chan ();
   fwic_rsp_if rsp_chan ();

   firmware_image_receiver_crc_check_core DUT (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   rx_state_type rx;
   cfg_type      regs;
   reply_type    pending_replies [$];
   int unsigned  fail_count = 0;
   int unsigned  items_sent = 0;
   bit           req_gaps = 1'b1;
   bit           rsp_gaps = 1'b1;
   logic         rsp_hold = 1'b0;
   int unsigned  rsp_wait;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   function automatic logic [31:0] crc_update(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = {24'd0, crc[7:0] ^ b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
      end
      return (crc >> 8) ^ c;
   endfunction

   function automatic logic [31:0] image_crc(input byte_queue_type data);
      logic [31:0] crc;
      crc = CRC_INIT;
      foreach (data[i]) crc = crc_update(crc, data[i]);
      return ~crc;
   endfunction

   function automatic void clear_receive();
      rx.byte_count   = '0;
      rx.expected_crc = '0;
      rx.image_size   = '0;
      rx.running_crc  = CRC_INIT;
      rx.stack_word   = '0;
      rx.entry_word   = '0;
   endfunction

   function automatic void clear_all();
      rx.synced     = 1'b0;
      rx.retries    = '0;
      rx.idle_ticks = '0;
      clear_receive();
   endfunction

   function automatic bit receiver_step(input logic cmd, input logic [7:0] b,
                                        output reply_type r);
      logic [COUNT_W-1:0] pos;
      logic [31:0]        crc;
      cause_type          why;
      r = '{RSP_ACK, CAUSE_NONE, 3'd0, 32'd0};
      if (cmd == ITEM_TICK) begin
         if (!rx.synced) return 1'b0;
         if (rx.idle_ticks != IDLE_MAX) rx.idle_ticks++;
         if (rx.idle_ticks > regs.timeout_ticks) begin
            r = '{RSP_RESET, CAUSE_TIMEOUT, rx.retries, 32'd0};
            clear_all();
            return 1'b1;
         end
         return 1'b0;
      end
      if (!rx.synced) begin
         if (b == SYNC_BYTE) begin
            rx.synced     = 1'b1;
            rx.retries    = '0;
            rx.idle_ticks = '0;
         end
         return 1'b0;
      end
      rx.idle_ticks = '0;
      if (rx.byte_count >= BUFFER_BYTES) return 1'b0;
      pos = rx.byte_count;
      if (pos >= 4 && pos < 8) begin
         rx.expected_crc[8*(pos-4) +: 8] = b;
      end else if (pos >= 8 && pos < HEADER_BYTES) begin
         rx.image_size[8*(pos-8) +: 8] = b;
      end else if (pos >= HEADER_BYTES) begin
         rx.running_crc = crc_update(rx.running_crc, b);
         if (pos < 16) rx.stack_word[8*(pos-12) +: 8] = b;
         else if (pos < 20) rx.entry_word[8*(pos-16) +: 8] = b;
      end
      rx.byte_count = pos + 1'b1;
      if (rx.byte_count < HEADER_BYTES ||
          33'(rx.byte_count) != 33'(rx.image_size) + 33'(HEADER_BYTES))
         return 1'b0;

      crc = ~rx.running_crc;
      if (crc != rx.expected_crc) begin
         why = CAUSE_CRC;
      end else if (rx.stack_word >= regs.stack_low && rx.stack_word <= regs.stack_high &&
                   rx.entry_word >= regs.entry_low && rx.entry_word <= regs.entry_high) begin
         r = '{RSP_ACK, CAUSE_NONE, 3'd0, crc};
         rx.retries = '0;
         rx.synced  = 1'b0;
         clear_receive();
         return 1'b1;
      end else begin
         why = CAUSE_VECTOR;
      end

      if (rx.retries != RETRY_SAT) rx.retries++;
      r.cause        = why;
      r.attempt      = rx.retries;
      r.computed_crc = crc;
      if (rx.retries >= regs.retry_limit) begin
         r.response = RSP_FATAL;
         rx.retries = '0;
         rx.synced  = 1'b0;
      end else begin
         r.response = RSP_NAK;
         if (why == CAUSE_VECTOR) rx.synced = 1'b0;
      end
      clear_receive();
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------- checking

   function automatic void compare_field(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin : check_replies
      reply_type want;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (pending_replies.size() == 0) begin
            $display("%0t: unexpected reply, expected none, actual rsp=%0d cause=%0d att=%0d crc=%h",
                     $time, rsp_chan.response, rsp_chan.cause, rsp_chan.attempt,
                     rsp_chan.computed_crc);
            fail_count++;
         end else begin
            want = pending_replies.pop_front();
            compare_field("response", 32'(want.response), 32'(rsp_chan.response));
            compare_field("cause", 32'(want.cause), 32'(rsp_chan.cause));
            compare_field("attempt", 32'(want.attempt), 32'(rsp_chan.attempt));
            compare_field("computed_crc", want.computed_crc, rsp_chan.computed_crc);
         end
      end
   end

   // Hold ready low for a random wait after each reply when gaps are on, and for as long as the hold is on.
   always @(posedge clock) begin
      if (reset) begin
         rsp_wait = 0;
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1)
            rsp_wait = rsp_gaps ? $urandom_range(0, 19) : 0;
         else if (rsp_wait != 0)
            rsp_wait--;
         rsp_chan.ready <= (rsp_wait == 0) && !rsp_hold;
      end
   end

   // ---------------------------------------------------------------- drivers

   task automatic hold_replies(input int unsigned cycles);
      rsp_hold <= 1'b1;
      repeat (cycles) @(posedge clock);
      rsp_hold <= 1'b0;
   endtask

   task automatic send_item(input logic cmd, input logic [7:0] b);
      int unsigned gap;
      reply_type   r;
      gap = req_gaps ? $urandom_range(0, 19) : 0;
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.command   <= cmd;
      req_chan.data_byte <= b;
      @(posedge clock);
      while (req_chan.ready !== 1'b1) @(posedge clock);
      items_sent++;
      if (receiver_step(cmd, b, r)) pending_replies.push_back(r);
   endtask

   // Send header and payload; a tick is slipped in before a byte with the given chance.
   task automatic send_image(input logic [31:0] magic, input logic [31:0] crc,
                             input logic [31:0] size, input byte_queue_type data,
                             input int unsigned tick_pct);
      logic [31:0]    hdr [3];
      byte_queue_type all;
      hdr = '{magic, crc, size};
      for (int w = 0; w < 3; w++)
         for (int k = 0; k < 4; k++) all.push_back(hdr[w][8*k +: 8]);
      foreach (data[i]) all.push_back(data[i]);
      foreach (all[i]) begin
         if (tick_pct != 0 && $urandom_range(0, 99) < tick_pct)
            send_item(ITEM_TICK, 8'($urandom));
         send_item(ITEM_BYTE, all[i]);
      end
   endtask

   task automatic settle();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] index, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'({index, 2'b00});
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (csr_pready !== 1'b1) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (index)
         REG_TIMEOUT:     regs.timeout_ticks = value[19:0];
         REG_RETRY_LIMIT: regs.retry_limit   = value[2:0];
         REG_STACK_LOW:   regs.stack_low     = value;
         REG_STACK_HIGH:  regs.stack_high    = value;
         REG_ENTRY_LOW:   regs.entry_low     = value;
         REG_ENTRY_HIGH:  regs.entry_high    = value;
         default: ;
      endcase
   endtask

   function automatic byte_queue_type make_payload(input logic [31:0] stack,
                                                   input logic [31:0] entry,
                                                   input int unsigned len);
      byte_queue_type q;
      logic [63:0]    vec;
      vec = {entry, stack};
      for (int unsigned i = 0; i < len; i++) begin
         if (i < 8) q.push_back(vec[8*i +: 8]);
         else q.push_back(8'($urandom));
      end
      return q;
   endfunction

   function automatic logic [31:0] random_word();
      case ($urandom_range(0, 3))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] pick_in_range(input logic [31:0] lo, input logic [31:0] hi);
      logic [32:0] span;
      if (lo > hi) return $urandom;
      span = 33'(hi) - 33'(lo) + 33'd1;
      case ($urandom_range(0, 2))
         0: return lo;
         1: return hi;
         default: return lo + 32'(33'($urandom) % span);
      endcase
   endfunction

   // ---------------------------------------------------------------- tests

   task automatic test_basic_images();
      byte_queue_type none;
      byte_queue_type p;
      req_gaps = 1'b1;
      rsp_gaps = 1'b1;
      // noise and ticks before sync are dropped
      send_item(ITEM_BYTE, 8'h00);
      send_item(ITEM_BYTE, 8'hFF);
      send_item(ITEM_TICK, 8'hFF);
      send_item(ITEM_BYTE, SYNC_BYTE);
      // empty image: CRC of nothing matches, zero vectors fail the range check
      send_image(32'hFFFF_FFFF, 32'h0, 32'h0, none, 0);
      p = make_payload(STACK_LOW_RST, ENTRY_HIGH_RST, 8);
      send_item(ITEM_BYTE, SYNC_BYTE);
      send_image(32'h0, ~image_crc(p), 32'd8, p, 0);
      // still synced after a CRC failure: retry without sync
      send_image(32'h0, image_crc(p), 32'd8, p, 0);
      // short image: entry word cut to its low byte, the rest left as zero
      p = make_payload(STACK_HIGH_RST, ENTRY_LOW_RST, 5);
      send_item(ITEM_BYTE, SYNC_BYTE);
      send_image(32'h1234_5678, image_crc(p), 32'd5, p, 0);
      settle();
   endtask

   task automatic test_retry_limits();
      byte_queue_type none;
      csr_write(REG_RETRY_LIMIT, 32'd1);
      send_item(ITEM_BYTE, SYNC_BYTE);
      send_image(32'h0, 32'h1, 32'h0, none, 0);
      settle();
      // zero limit: every failure is fatal
      csr_write(REG_RETRY_LIMIT, 32'd0);
      send_item(ITEM_BYTE, SYNC_BYTE);
      send_image(32'h0, 32'h1, 32'h0, none, 0);
      send_item(ITEM_BYTE, SYNC_BYTE);
      send_image(32'h0, 32'h0, 32'h0, none, 0);
      settle();
      csr_write(REG_RETRY_LIMIT, 32'd7);
      send_item(ITEM_BYTE, SYNC_BYTE);
      repeat (7) send_image(32'h0, 32'hDEAD_BEEF, 32'h0, none, 0);
      settle();
   endtask

   task automatic test_vector_ranges();
      byte_queue_type none;
      byte_queue_type p;
      csr_write(REG_RETRY_LIMIT, 32'd3);
      csr_write(REG_STACK_LOW, 32'h0000_0000);
      csr_write(REG_STACK_HIGH, 32'hFFFF_FFFF);
      csr_write(REG_ENTRY_LOW, 32'h0000_0000);
      csr_write(REG_ENTRY_HIGH, 32'hFFFF_FFFF);
      send_item(ITEM_BYTE, SYNC_BYTE);
      send_image(32'h0, 32'h0, 32'h0, none, 0);
      settle();
      // single-value ranges: hit, and one off on either side
      csr_write(REG_STACK_LOW, 32'h2000_1000);
      csr_write(REG_STACK_HIGH, 32'h2000_1000);
      csr_write(REG_ENTRY_LOW, 32'h0800_8001);
      csr_write(REG_ENTRY_HIGH, 32'h0800_8001);
      p = make_payload(32'h2000_1000, 32'h0800_8001, 12);
      send_item(ITEM_BYTE, SYNC_BYTE);
      send_image(32'h0, image_crc(p), 32'd12, p, 0);
      p = make_payload(32'h2000_1001, 32'h0800_8001, 8);
      send_item(ITEM_BYTE, SYNC_BYTE);
      send_image(32'h0, image_crc(p), 32'd8, p, 0);
      p = make_payload(32'h2000_0FFF, 32'h0800_8001, 8);
      send_item(ITEM_BYTE, SYNC_BYTE);
      send_image(32'h0, image_crc(p), 32'd8, p, 0);
      p = make_payload(32'h2000_1000, 32'h0800_8002, 8);
      send_item(ITEM_BYTE, SYNC_BYTE);
      send_image(32'h0, image_crc(p), 32'd8, p, 0);
      settle();
      // inverted range rejects everything
      csr_write(REG_STACK_LOW, 32'hFFFF_FFFF);
      csr_write(REG_STACK_HIGH, 32'h0000_0000);
      p = make_payload(32'h8000_0000, 32'h0800_8001, 8);
      send_item(ITEM_BYTE, SYNC_BYTE);
      send_image(32'h0, image_crc(p), 32'd8, p, 0);
      settle();
      csr_write(REG_STACK_LOW, 32'h0000_0000);
      csr_write(REG_STACK_HIGH, 32'hFFFF_FFFF);
      csr_write(REG_ENTRY_LOW, 32'h0000_0000);
      csr_write(REG_ENTRY_HIGH, 32'hFFFF_FFFF);
   endtask

   task automatic test_timeouts();
      byte_queue_type none;
      byte_queue_type p;
      csr_write(REG_TIMEOUT, 32'd1);
      send_item(ITEM_BYTE, SYNC_BYTE);
      send_item(ITEM_TICK, 8'h00);
      send_item(ITEM_BYTE, 8'hA5);
      send_item(ITEM_TICK, 8'h00);
      send_item(ITEM_TICK, 8'hFF);
      // timeout after a NAK reports the retry count
      send_item(ITEM_BYTE, SYNC_BYTE);
      send_image(32'h0, 32'h1, 32'h0, none, 0);
      send_item(ITEM_BYTE, 8'h11);
      send_item(ITEM_BYTE, 8'h22);
      send_item(ITEM_TICK, 8'h00);
      send_item(ITEM_TICK, 8'h00);
      // oversized image never completes; only the timeout ends it
      p = make_payload(32'h2000_0000, 32'h0800_8000, 6);
      send_item(ITEM_BYTE, SYNC_BYTE);
      send_image(32'h0, 32'h0, 32'hFFFF_FFFF, p, 0);
      send_item(ITEM_TICK, 8'h00);
      send_item(ITEM_TICK, 8'h00);
      settle();
      csr_write(REG_TIMEOUT, 32'hF_FFFF);
      send_item(ITEM_BYTE, SYNC_BYTE);
      repeat (5) send_item(ITEM_TICK, 8'h00);
      send_image(32'h0, 32'h0, 32'h0, none, 0);
      settle();
   endtask

   task automatic test_backpressure();
      byte_queue_type none;
      csr_write(REG_TIMEOUT, 32'd100);
      req_gaps = 1'b0;
      fork
         hold_replies(600);
         repeat (6) begin
            send_item(ITEM_BYTE, SYNC_BYTE);
            send_image(32'h0, 32'h0, 32'h0, none, 0);
            send_item(ITEM_TICK, 8'h00);
         end
      join
      settle();
      req_gaps = 1'b1;
   endtask

   task automatic test_random_streams(input int unsigned count);
      int unsigned    stop_at;
      int unsigned    size;
      int unsigned    plen;
      int unsigned    pick;
      bit             huge;
      logic [31:0]    a;
      logic [31:0]    b;
      logic [31:0]    crc;
      logic [31:0]    stack;
      logic [31:0]    entry;
      byte_queue_type p;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         case ($urandom_range(0, 3))
            0: csr_write(REG_TIMEOUT, 32'd1);
            1: csr_write(REG_TIMEOUT, $urandom_range(2, 40));
            2: csr_write(REG_TIMEOUT, 32'hF_FFFF);
            default: csr_write(REG_TIMEOUT, $urandom_range(41, 32'hF_FFFF));
         endcase
         csr_write(REG_RETRY_LIMIT, $urandom_range(0, 7));
         a = random_word();
         b = random_word();
         if (a > b && $urandom_range(0, 4) != 0) {a, b} = {b, a};
         csr_write(REG_STACK_LOW, a);
         csr_write(REG_STACK_HIGH, b);
         a = random_word();
         b = random_word();
         if (a > b && $urandom_range(0, 4) != 0) {a, b} = {b, a};
         csr_write(REG_ENTRY_LOW, a);
         csr_write(REG_ENTRY_HIGH, b);
         req_gaps = $urandom_range(0, 2) != 0;
         rsp_gaps = $urandom_range(0, 2) != 0;

         repeat ($urandom_range(4, 12)) begin
            if ($urandom_range(0, 9) == 0)
               repeat ($urandom_range(1, 3)) send_item(ITEM_BYTE, 8'($urandom));
            if (!rx.synced && $urandom_range(0, 9) != 0) send_item(ITEM_BYTE, SYNC_BYTE);
            huge = 1'b0;
            pick = $urandom_range(0, 19);
            if (pick < 14) size = $urandom_range(0, 20);
            else if (pick < 18) size = $urandom_range(21, 48);
            else if (pick == 18 || regs.timeout_ticks > 40) size = $urandom_range(0, 3);
            else begin
               huge = 1'b1;
               size = $urandom_range(BUFFER_BYTES, 32'hFFFF_FFFF);
            end
            stack = $urandom_range(0, 4) != 0 ? pick_in_range(regs.stack_low, regs.stack_high)
                                              : random_word();
            entry = $urandom_range(0, 4) != 0 ? pick_in_range(regs.entry_low, regs.entry_high)
                                              : random_word();
            plen = huge ? $urandom_range(0, 30) : size;
            p = make_payload(stack, entry, plen);
            crc = $urandom_range(0, 3) != 0 ? image_crc(p) : $urandom;
            // broken sequence: cut the payload short
            if ($urandom_range(0, 9) == 0)
               while (p.size() > 0 && $urandom_range(0, 3) != 0) void'(p.pop_back());
            send_image($urandom, crc, size, p, $urandom_range(0, 1) ? 10 : 0);
            if (regs.timeout_ticks <= 40 && (huge || $urandom_range(0, 3) == 0))
               repeat (regs.timeout_ticks + 1) send_item(ITEM_TICK, 8'($urandom));
         end
         settle();
      end
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.command   = ITEM_BYTE;
      req_chan.data_byte = 8'h00;
      rsp_chan.ready     = 1'b0;
      csr_psel           = 1'b0;
      csr_penable        = 1'b0;
      csr_pwrite         = 1'b0;
      csr_paddr          = '0;
      csr_pwdata         = '0;
      regs = '{TIMEOUT_RST, RETRY_LIMIT_RST, STACK_LOW_RST, STACK_HIGH_RST,
               ENTRY_LOW_RST, ENTRY_HIGH_RST};
      clear_all();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_basic_images();
      test_retry_limits();
      test_vector_ranges();
      test_timeouts();
      test_backpressure();
      test_random_streams(300);

      settle();
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule

// ----- firmware_image_receiver_crc_check_core.f -----
+incdir+rtl
rtl/fwic_pkg.sv
rtl/fwic_channels.sv
rtl/fwic_csr.sv
rtl/fwic_front.sv
rtl/fwic_back.sv
rtl/firmware_image_receiver_crc_check_core.sv
verif/tb.sv
